/* rtl/pfp_pkg.sv */
// pfp_pkg: shared types and constants of the provisioning frame parser
// parse phases, result item layout, codes, register indexes, queue sizing
// no dependencies
`default_nettype none

package pfp_pkg;

   typedef enum logic [2:0] {
      PH_CMD,
      PH_LEN,
      PH_NAMELEN,
      PH_NAME,
      PH_SECLEN,
      PH_SECRET,
      PH_DONE,
      PH_OTHER
   } phase_type;

   localparam logic [1:0] KIND_NAME   = 2'd0;
   localparam logic [1:0] KIND_SECRET = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_BAD_SUM   = 2'd2;

   localparam logic CSR_CHECKSUM_ENABLE = 1'b0;
   localparam logic CSR_SETTINGS_CODE   = 1'b1;

   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_DEPTH = 2 ** FIFO_PTR_W;
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef struct packed {
      logic [1:0] item_kind;
      logic [7:0] payload_byte;
      logic [1:0] status;
      logic [7:0] command_code;
      logic       last;
   } rsp_item_type;

   // up to two results per transaction, in delivery order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } core_out_type;

endpackage

`default_nettype wire

/* rtl/pfp_ifs.sv */
// channel interfaces of the provisioning frame parser
// request bytes, result items and register writes; no dependencies
`default_nettype none

interface pfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface pfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] item_kind;
   logic [7:0] payload_byte;
   logic [1:0] status;
   logic [7:0] command_code;
   logic       last;

   modport source (output valid, output item_kind, output payload_byte, output status,
                   output command_code, output last, input ready);
   modport sink   (input valid, input item_kind, input payload_byte, input status,
                   input command_code, input last, output ready);
endinterface

interface pfp_csr_if;
   logic       valid;
   logic       ready;
   logic       reg_index;
   logic [7:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

/* rtl/pfp_frame_core.sv */
// pfp_frame_core: per-byte frame state and result generation
// depends on pfp_pkg
`default_nettype none

module pfp_frame_core
   import pfp_pkg::*;
#(
   parameter int MAX_NAME_BYTES   = 32,
   parameter int MAX_SECRET_BYTES = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   rx_byte,
   input  wire logic         frame_end,
   input  wire logic         checksum_enable,
   input  wire logic [7:0]   settings_code,
   output core_out_type      result
);

   localparam logic [7:0] NameLimit   = 8'(MAX_NAME_BYTES);
   localparam logic [7:0] SecretLimit = 8'(MAX_SECRET_BYTES);

   logic [8:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] dlen_ff, dlen_in;
   logic [7:0] name_len_ff, name_len_in;
   logic [7:0] secret_len_ff, secret_len_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] fcount_ff, fcount_in;
   logic       zero_seen_ff, zero_seen_in;
   logic       field_error_ff, field_error_in;

   // values after this byte, before the end-of-frame clear
   logic [7:0] w_cmd, w_dlen, w_name_len, w_secret_len, w_fcount;
   phase_type  w_phase;
   logic       w_zero_seen, w_field_error;

   logic       in_payload;
   logic       stream_hit;
   logic [7:0] fcount_inc;
   logic [9:0] byte_count, expect_count;
   logic [1:0] frame_status;
   rsp_item_type stream_item, status_item;

   assign fcount_inc = fcount_ff + 8'd1;

   assign in_payload = (pos_ff >= 9'd2) && ((pos_ff - 9'd2) < {1'b0, dlen_ff})
                       && !(frame_end && checksum_enable)
                       && (phase_ff != PH_OTHER) && (phase_ff != PH_DONE);

   // next state
   always_comb begin
      w_cmd         = cmd_ff;
      w_dlen        = dlen_ff;
      w_name_len    = name_len_ff;
      w_secret_len  = secret_len_ff;
      w_fcount      = fcount_ff;
      w_phase       = phase_ff;
      w_zero_seen   = zero_seen_ff;
      w_field_error = field_error_ff;

      if (pos_ff == 9'd0) begin
         w_cmd   = rx_byte;
         w_phase = PH_LEN;
      end else if (pos_ff == 9'd1) begin
         w_dlen  = rx_byte;
         w_phase = (cmd_ff == settings_code) ? PH_NAMELEN : PH_OTHER;
      end else if (in_payload) begin
         case (phase_ff)
            PH_NAMELEN: begin
               w_name_len  = rx_byte;
               if (rx_byte > NameLimit) w_field_error = 1'b1;
               w_fcount    = 8'd0;
               w_zero_seen = 1'b0;
               w_phase     = (rx_byte == 8'd0) ? PH_SECLEN : PH_NAME;
            end
            PH_SECLEN: begin
               w_secret_len = rx_byte;
               if (rx_byte > SecretLimit) w_field_error = 1'b1;
               w_fcount     = 8'd0;
               w_zero_seen  = 1'b0;
               w_phase      = (rx_byte == 8'd0) ? PH_DONE : PH_SECRET;
            end
            PH_NAME: begin
               if (!zero_seen_ff && !field_error_ff && rx_byte == 8'd0) w_zero_seen = 1'b1;
               w_fcount = fcount_inc;
               if (fcount_inc == name_len_ff) w_phase = PH_SECLEN;
            end
            PH_SECRET: begin
               if (!zero_seen_ff && !field_error_ff && rx_byte == 8'd0) w_zero_seen = 1'b1;
               w_fcount = fcount_inc;
               if (fcount_inc == secret_len_ff) w_phase = PH_DONE;
            end
            default: begin
            end
         endcase
      end

      if (frame_end) begin
         pos_in         = '0;
         sum_in         = '0;
         cmd_in         = '0;
         dlen_in        = '0;
         name_len_in    = '0;
         secret_len_in  = '0;
         phase_in       = PH_CMD;
         fcount_in      = '0;
         zero_seen_in   = 1'b0;
         field_error_in = 1'b0;
      end else begin
         pos_in         = (pos_ff == 9'h1FF) ? pos_ff : pos_ff + 9'd1;
         sum_in         = sum_ff + rx_byte;
         cmd_in         = w_cmd;
         dlen_in        = w_dlen;
         name_len_in    = w_name_len;
         secret_len_in  = w_secret_len;
         phase_in       = w_phase;
         fcount_in      = w_fcount;
         zero_seen_in   = w_zero_seen;
         field_error_in = w_field_error;
      end
   end

   // results
   always_comb begin
      stream_hit = in_payload && (phase_ff == PH_NAME || phase_ff == PH_SECRET)
                   && !zero_seen_ff && !field_error_ff && (rx_byte != 8'd0);

      byte_count   = {1'b0, pos_ff} + 10'd1;
      expect_count = {2'b0, w_dlen} + 10'd2 + {9'd0, checksum_enable};

      if (byte_count != expect_count) begin
         frame_status = ST_MALFORMED;
      end else if (checksum_enable && sum_ff != rx_byte) begin
         frame_status = ST_BAD_SUM;
      end else if (w_phase == PH_OTHER) begin
         frame_status = ST_OK;
      end else if (w_field_error || w_phase != PH_DONE) begin
         frame_status = ST_MALFORMED;
      end else begin
         frame_status = ST_OK;
      end

      stream_item.item_kind    = (phase_ff == PH_NAME) ? KIND_NAME : KIND_SECRET;
      stream_item.payload_byte = rx_byte;
      stream_item.status       = ST_OK;
      stream_item.command_code = 8'd0;
      stream_item.last         = 1'b0;

      status_item.item_kind    = KIND_STATUS;
      status_item.payload_byte = 8'd0;
      status_item.status       = frame_status;
      status_item.command_code = w_cmd;
      status_item.last         = 1'b1;

      result.count = accept ? ({1'b0, stream_hit} + {1'b0, frame_end}) : 2'd0;
      result.item0 = stream_hit ? stream_item : status_item;
      result.item1 = status_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         sum_ff         <= '0;
         cmd_ff         <= '0;
         dlen_ff        <= '0;
         name_len_ff    <= '0;
         secret_len_ff  <= '0;
         phase_ff       <= PH_CMD;
         fcount_ff      <= '0;
         zero_seen_ff   <= 1'b0;
         field_error_ff <= 1'b0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         sum_ff         <= sum_in;
         cmd_ff         <= cmd_in;
         dlen_ff        <= dlen_in;
         name_len_ff    <= name_len_in;
         secret_len_ff  <= secret_len_in;
         phase_ff       <= phase_in;
         fcount_ff      <= fcount_in;
         zero_seen_ff   <= zero_seen_in;
         field_error_ff <= field_error_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/pfp_rsp_fifo.sv */
// pfp_rsp_fifo: result queue, up to two writes and one read per cycle
// depends on pfp_pkg
`default_nettype none

module pfp_rsp_fifo
   import pfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire core_out_type push,
   output logic              space_ok,
   input  wire logic         pop,
   output logic              head_valid,
   output rsp_item_type      head_item
);

   rsp_item_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_next;
   logic                    do_pop;

   assign do_pop      = pop && (count_ff != '0);
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + FIFO_PTR_W'(do_pop);
   assign count_in    = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(do_pop);

   // room for a whole transaction's worth of results
   assign space_ok   = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) slot_ff[wr_ptr_ff] <= push.item0;
      if (push.count == 2'd2) slot_ff[wr_ptr_next] <= push.item1;
   end

endmodule

`default_nettype wire

/* rtl/provisioning_frame_parser_top.sv */
// provisioning_frame_parser_top: RPC frame parser, top level
// depends on pfp_pkg, pfp_ifs, pfp_frame_core, pfp_rsp_fifo
//
// Usage:
//   req_bus carries one frame byte per transaction, frame_end high on the
//   final byte. rsp_bus returns name bytes and password bytes of a wifi
//   settings frame as they arrive (zero bytes and bytes after a field's first
//   zero are dropped), then one status item with last high per frame.
//   Streamed bytes are to be discarded unless that status is ok.
//   csr_bus writes checksum_enable (index 0) and settings_command_code
//   (index 1); it is always ready and should be used only while idle.
// Timing:
//   a result enters the result queue as its byte is taken; one byte is taken
//   every cycle while the queue has room. A byte makes at most two results and
//   the four-entry queue takes a byte while it holds two or fewer items, so a
//   receiver taking one item per cycle never slows the input.
// Reset:
//   synchronous; clears the frame state and the result queue, sets
//   checksum_enable to 1 and the settings command code to 1.
// Stall:
//   when rsp_bus.ready stays low the queue fills and req_bus.ready drops;
//   no result is lost or repeated.
`default_nettype none

module provisioning_frame_parser_top
   import pfp_pkg::*;
#(
   parameter int MAX_NAME_BYTES   = 32,
   parameter int MAX_SECRET_BYTES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pfp_req_if.sink    req_bus,
   pfp_rsp_if.source  rsp_bus,
   pfp_csr_if.sink    csr_bus
);

   logic         checksum_enable_ff;
   logic [7:0]   settings_code_ff;
   logic         req_accept;
   logic         space_ok;
   logic         head_valid;
   core_out_type core_result;
   rsp_item_type head_item;

   assign csr_bus.ready   = 1'b1;
   assign req_bus.ready   = space_ok;
   assign req_accept      = req_bus.valid && space_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         checksum_enable_ff <= 1'b1;
         settings_code_ff   <= 8'd1;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_CHECKSUM_ENABLE: checksum_enable_ff <= csr_bus.wr_data[0];
            CSR_SETTINGS_CODE:   settings_code_ff   <= csr_bus.wr_data;
            default: begin
            end
         endcase
      end
   end

   pfp_frame_core #(
      .MAX_NAME_BYTES   (MAX_NAME_BYTES),
      .MAX_SECRET_BYTES (MAX_SECRET_BYTES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .rx_byte         (req_bus.rx_byte),
      .frame_end       (req_bus.frame_end),
      .checksum_enable (checksum_enable_ff),
      .settings_code   (settings_code_ff),
      .result          (core_result)
   );

   pfp_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (core_result),
      .space_ok   (space_ok),
      .pop        (rsp_bus.ready),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   assign rsp_bus.valid        = head_valid;
   assign rsp_bus.item_kind    = head_item.item_kind;
   assign rsp_bus.payload_byte = head_item.payload_byte;
   assign rsp_bus.status       = head_item.status;
   assign rsp_bus.command_code = head_item.command_code;
   assign rsp_bus.last         = head_item.last;

   // the end of a frame always leaves a result waiting
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.frame_end) |=> rsp_bus.valid)
      else $error("frame end produced no result");

   // status items and only status items close a frame
   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.last == (rsp_bus.item_kind == KIND_STATUS)))
      else $error("last flag does not match item kind");

   // a streamed field byte is never the zero terminator
   a_stream_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.item_kind != KIND_STATUS) |->
         (rsp_bus.payload_byte != 8'd0 && rsp_bus.status == ST_OK))
      else $error("bad streamed byte");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for provisioning_frame_parser_top: random and directed frames over the byte channel,
// results checked against an in-bench frame predictor
// depends on pfp_pkg, pfp_ifs and the parser rtl
module testbench;
   import pfp_pkg::*;

   localparam int NAME_CAP     = 32;
   localparam int SECRET_CAP   = 64;
   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_BYTES  = 20;
   localparam int PHASE_COUNT  = 5;

   typedef struct packed {
      logic [7:0] value;
      logic       fin;
   } link_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pfp_req_if req_bus();
   pfp_rsp_if rsp_bus();
   pfp_csr_if csr_bus();

   provisioning_frame_parser_top #(
      .MAX_NAME_BYTES(NAME_CAP),
      .MAX_SECRET_BYTES(SECRET_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   logic       byte_valid = 1'b0;
   logic [7:0] byte_value = 8'd0;
   logic       byte_fin   = 1'b0;
   logic       take_ready = 1'b0;
   logic       reg_valid  = 1'b0;
   logic       reg_sel    = CSR_CHECKSUM_ENABLE;
   logic [7:0] reg_data   = 8'd0;

   assign req_bus.valid     = byte_valid;
   assign req_bus.rx_byte   = byte_value;
   assign req_bus.frame_end = byte_fin;
   assign rsp_bus.ready     = take_ready;
   assign csr_bus.valid     = reg_valid;
   assign csr_bus.reg_index = reg_sel;
   assign csr_bus.wr_data   = reg_data;

   link_byte_type outgoing_bytes[$];
   rsp_item_type  awaited_items[$];
   int            bytes_queued = 0;
   int            bytes_taken  = 0;
   int            error_total  = 0;
   int            idle_cycles  = 0;
   bit            steady_run   = 1'b0;
   logic          gen_sum_on   = 1'b1;
   logic [7:0]    gen_code     = 8'd1;

   // predictor copy of the registers and the frame state
   logic       sum_on        = 1'b1;
   logic [7:0] settings_code = 8'd1;
   logic [8:0] frame_pos     = 9'd0;
   logic [7:0] frame_sum     = 8'd0;
   logic [7:0] frame_cmd     = 8'd0;
   logic [7:0] payload_len   = 8'd0;
   logic [7:0] name_len      = 8'd0;
   logic [7:0] secret_len    = 8'd0;
   logic [7:0] field_cnt     = 8'd0;
   phase_type  phase         = PH_CMD;
   logic       zero_hit      = 1'b0;
   logic       size_error    = 1'b0;

   function automatic rsp_item_type result_item(input logic [1:0] kind, input logic [7:0] data,
                                                input logic [1:0] st, input logic [7:0] cmd,
                                                input logic fin);
      rsp_item_type it;
      it.item_kind    = kind;
      it.payload_byte = data;
      it.status       = st;
      it.command_code = cmd;
      it.last         = fin;
      return it;
   endfunction

   // advances the frame state by one byte and queues the items it produces
   task automatic parse_byte(input logic [7:0] b, input logic fin);
      logic       is_name;
      logic [7:0] flen;
      logic [1:0] st;
      int         seen_count;
      int         want_count;
      if (frame_pos == 9'd0) begin
         frame_cmd = b;
         phase = PH_LEN;
      end else if (frame_pos == 9'd1) begin
         payload_len = b;
         phase = (frame_cmd == settings_code) ? PH_NAMELEN : PH_OTHER;
      end else if (int'(frame_pos) - 2 < int'(payload_len) && !(fin && sum_on)) begin
         case (phase)
            PH_NAMELEN, PH_SECLEN: begin
               is_name = (phase == PH_NAMELEN);
               if (is_name) name_len = b;
               else secret_len = b;
               if (int'(b) > (is_name ? NAME_CAP : SECRET_CAP)) size_error = 1'b1;
               field_cnt = 8'd0;
               zero_hit = 1'b0;
               if (b == 8'd0) phase = is_name ? PH_SECLEN : PH_DONE;
               else phase = is_name ? PH_NAME : PH_SECRET;
            end
            PH_NAME, PH_SECRET: begin
               is_name = (phase == PH_NAME);
               flen = is_name ? name_len : secret_len;
               // a field stops streaming at its first zero byte
               if (!zero_hit && !size_error) begin
                  if (b == 8'd0) zero_hit = 1'b1;
                  else awaited_items.push_back(result_item(is_name ? KIND_NAME : KIND_SECRET,
                                                           b, ST_OK, 8'd0, 1'b0));
               end
               field_cnt = field_cnt + 8'd1;
               if (field_cnt == flen) phase = is_name ? PH_SECLEN : PH_DONE;
            end
            default: ;
         endcase
      end

      if (fin) begin
         seen_count = int'(frame_pos) + 1;
         want_count = int'(payload_len) + 2 + int'(sum_on);
         if (seen_count != want_count) st = ST_MALFORMED;
         else if (sum_on && frame_sum != b) st = ST_BAD_SUM;
         else if (phase == PH_OTHER) st = ST_OK;
         else if (size_error || phase != PH_DONE) st = ST_MALFORMED;
         else st = ST_OK;
         awaited_items.push_back(result_item(KIND_STATUS, 8'd0, st, frame_cmd, 1'b1));
         frame_pos   = 9'd0;
         frame_sum   = 8'd0;
         frame_cmd   = 8'd0;
         payload_len = 8'd0;
         name_len    = 8'd0;
         secret_len  = 8'd0;
         field_cnt   = 8'd0;
         phase       = PH_CMD;
         zero_hit    = 1'b0;
         size_error  = 1'b0;
      end else begin
         frame_sum = frame_sum + b;
         if (frame_pos < 9'd511) frame_pos = frame_pos + 9'd1;
      end
   endtask

   task automatic flag_error(input string msg);
      error_total++;
      if (error_total <= 10) $display("%s", msg);
   endtask

   // appends a frame, optionally with its checksum (or a corrupted one)
   task automatic send_frame(input logic [7:0] body[$], input logic add_sum, input logic spoil);
      logic [7:0] total;
      link_byte_type lb;
      total = 8'd0;
      foreach (body[i]) total = total + body[i];
      if (add_sum) body.push_back(spoil ? total ^ 8'($urandom_range(255, 1)) : total);
      foreach (body[i]) begin
         lb.value = body[i];
         lb.fin = (i == body.size() - 1);
         outgoing_bytes.push_back(lb);
      end
      bytes_queued += body.size();
   endtask

   function automatic int field_len(input int cap);
      int r;
      r = $urandom_range(99);
      if (r < 75) return $urandom_range(8, 0);
      else if (r < 88) return $urandom_range(cap, cap - 4);
      else return $urandom_range(cap + 6, cap + 1);
   endfunction

   function automatic logic [7:0] stream_byte();
      return ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
   endfunction

   task automatic wait_drained();
      while (bytes_taken != bytes_queued || awaited_items.size() != 0) @(posedge clock);
   endtask

   // caller enters right after a rising edge; valid stays high for a following write
   task automatic write_reg(input logic sel, input logic [7:0] data);
      reg_valid <= 1'b1;
      reg_sel   <= sel;
      reg_data  <= data;
      do @(posedge clock); while (!(reg_valid && csr_bus.ready));
      if (sel == CSR_CHECKSUM_ENABLE) sum_on = data[0];
      else settings_code = data;
   endtask

   // byte driver
   always @(posedge clock) begin
      link_byte_type nxt;
      if (reset) begin
         byte_valid <= 1'b0;
      end else begin
         if (byte_valid && req_bus.ready) begin
            parse_byte(byte_value, byte_fin);
            bytes_taken++;
         end
         if (!byte_valid || req_bus.ready) begin
            if (outgoing_bytes.size() > 0 && (steady_run || $urandom_range(99) >= 28)) begin
               nxt = outgoing_bytes.pop_front();
               byte_valid <= 1'b1;
               byte_value <= nxt.value;
               byte_fin   <= nxt.fin;
            end else begin
               byte_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && take_ready) begin
            seen = result_item(rsp_bus.item_kind, rsp_bus.payload_byte, rsp_bus.status,
                               rsp_bus.command_code, rsp_bus.last);
            if (awaited_items.size() == 0) begin
               flag_error($sformatf("unexpected item: kind %0d byte %02h status %0d cmd %02h last %0d",
                                    seen.item_kind, seen.payload_byte, seen.status,
                                    seen.command_code, seen.last));
            end else begin
               want = awaited_items.pop_front();
               if (seen.item_kind !== want.item_kind || seen.payload_byte !== want.payload_byte ||
                   seen.status !== want.status || seen.command_code !== want.command_code ||
                   seen.last !== want.last)
                  flag_error($sformatf({"mismatch: expected kind %0d byte %02h status %0d cmd %02h",
                                        " last %0d, got kind %0d byte %02h status %0d cmd %02h",
                                        " last %0d"},
                                       want.item_kind, want.payload_byte, want.status,
                                       want.command_code, want.last, seen.item_kind,
                                       seen.payload_byte, seen.status, seen.command_code,
                                       seen.last));
            end
         end
         take_ready <= steady_run || ($urandom_range(99) >= 28);
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (byte_valid && req_bus.ready) || (rsp_bus.valid && take_ready) ||
          (reg_valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [7:0] frame_q[$];
      int         nlen;
      int         slen;
      int         kind;
      int         flaw;
      int         cut;
      int         phase_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         gen_sum_on = (ph % 2 == 0);
         case (ph)
            0, 1: gen_code = 8'd1;
            2: gen_code = 8'd0;
            3: gen_code = 8'hFF;
            default: gen_code = 8'hA5;
         endcase
         write_reg(CSR_CHECKSUM_ENABLE, {7'd0, gen_sum_on});
         write_reg(CSR_SETTINGS_CODE, gen_code);
         reg_valid <= 1'b0;
         steady_run = (ph == 2);
         phase_start = bytes_queued;

         if (ph == 0) begin
            // one-byte frame
            frame_q.delete();
            frame_q.push_back(8'hFF);
            send_frame(frame_q, 1'b0, 1'b0);
            // good settings frame, extreme byte values in both fields
            frame_q = {gen_code, 8'd4, 8'd1, 8'hFF, 8'd1, 8'h01};
            send_frame(frame_q, 1'b1, 1'b0);
            // oversize name whose declared length runs past the payload
            frame_q = {gen_code, 8'd2, 8'd33, 8'h00};
            send_frame(frame_q, 1'b1, 1'b0);
            // bad checksum on another command
            frame_q = {8'h00, 8'h00};
            send_frame(frame_q, 1'b1, 1'b1);
            // frame longer than its declared length
            frame_q = {8'hFF, 8'h00, 8'h00, 8'hFF};
            send_frame(frame_q, 1'b1, 1'b0);
         end

         if (ph == 3) begin
            // long enough to saturate the byte position counter
            frame_q = {gen_code, 8'd40};
            repeat (512) frame_q.push_back(8'($urandom));
            send_frame(frame_q, 1'b0, 1'b0);
         end

         while (bytes_queued - phase_start < PHASE_BYTES) begin
            kind = $urandom_range(99);
            frame_q.delete();
            if (kind < 85) begin
               frame_q.push_back(kind < 65 ? gen_code : 8'($urandom));
               frame_q.push_back(8'd0);
               if (kind < 65) begin
                  nlen = field_len(NAME_CAP);
                  slen = field_len(SECRET_CAP);
                  frame_q.push_back(8'(nlen));
                  repeat (nlen) frame_q.push_back(stream_byte());
                  frame_q.push_back(8'(slen));
                  repeat (slen) frame_q.push_back(stream_byte());
                  repeat ($urandom_range(2)) frame_q.push_back(8'($urandom));
               end else begin
                  repeat ($urandom_range(6)) frame_q.push_back(8'($urandom));
               end
               flaw = $urandom_range(99);
               // payload cut short so declared fields run past it
               if (flaw < 8 && frame_q.size() > 2) begin
                  cut = $urandom_range(frame_q.size() - 1, 2);
                  while (frame_q.size() > cut) frame_q.pop_back();
               end
               frame_q[1] = 8'(frame_q.size() - 2);
               if (flaw >= 8 && flaw < 16) frame_q[1] += ($urandom_range(1) ? 8'd1 : 8'hFF);
               send_frame(frame_q, gen_sum_on, flaw >= 16 && flaw < 26);
            end else begin
               repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom));
               send_frame(frame_q, 1'b0, 1'b0);
            end
         end

         wait_drained();
         repeat (4) @(posedge clock);
      end

      steady_run = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (awaited_items.size() != 0)
         flag_error($sformatf("%0d expected items never arrived", awaited_items.size()));
      if (error_total == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/pfp_pkg.sv
rtl/pfp_ifs.sv
rtl/pfp_frame_core.sv
rtl/pfp_rsp_fifo.sv
rtl/provisioning_frame_parser_top.sv
tb/testbench.sv
